[rtl/dsfp_pkg.sv]
// Shared types, constants and functions for the desk status frame parser.
package dsfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int RAW_W       = 16;
  localparam int CRC_W       = 16;
  localparam int HEIGHT_W    = 13;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] FRAME_BYTES = 4'd14;
  localparam logic [CNT_W-1:0] CRC_BYTES   = 4'd10;

  localparam logic [CNT_W-1:0] IDX_HDR0     = 4'd0;
  localparam logic [CNT_W-1:0] IDX_HDR1     = 4'd1;
  localparam logic [CNT_W-1:0] IDX_CRC_FIRST = 4'd2;
  localparam logic [CNT_W-1:0] IDX_FAULT    = 4'd4;
  localparam logic [CNT_W-1:0] IDX_MEM_HI   = 4'd5;
  localparam logic [CNT_W-1:0] IDX_MEM_LO   = 4'd6;
  localparam logic [CNT_W-1:0] IDX_CUR_HI   = 4'd7;
  localparam logic [CNT_W-1:0] IDX_CUR_LO   = 4'd8;
  localparam logic [CNT_W-1:0] IDX_STATUS   = 4'd11;
  localparam logic [CNT_W-1:0] IDX_CRC_LO   = 4'd12;
  localparam logic [CNT_W-1:0] IDX_CRC_HI   = 4'd13;

  localparam logic [BYTE_W-1:0] HDR0 = 8'hE4;
  localparam logic [BYTE_W-1:0] HDR1 = 8'hF7;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // mm = H_MIN + trunc((raw - RAW_OFFSET) * H_SPAN / RAW_SPAN)
  localparam int RAW_OFFSET  = 45;
  localparam int RAW_SPAN    = 4707;
  localparam int H_MIN       = 720;
  localparam int H_SPAN      = 480;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (H_SPAN << RECIP_SHIFT) / RAW_SPAN;
  localparam int RECIP_W     = 13;
  localparam int SPAN_PROD_W = 25;

  localparam logic [BYTE_W-1:0] ST_BYTE_BOTTOM  = 8'h00;
  localparam logic [BYTE_W-1:0] ST_BYTE_BETWEEN = 8'h01;
  localparam logic [BYTE_W-1:0] ST_BYTE_MAX     = 8'h02;
  localparam logic [BYTE_W-1:0] ST_BYTE_SLOW    = 8'h10;
  localparam logic [BYTE_W-1:0] ST_BYTE_FAST    = 8'h20;
  localparam logic [BYTE_W-1:0] ST_BYTE_RESET   = 8'h04;

  typedef enum logic [1:0] {
    FS_OK         = 2'd0,
    FS_BAD_HEADER = 2'd1,
    FS_CRC_ERROR  = 2'd2
  } frame_status_t;

  typedef enum logic [2:0] {
    POS_UNKNOWN = 3'd0,
    POS_BOTTOM  = 3'd1,
    POS_BETWEEN = 3'd2,
    POS_MAX     = 3'd3,
    POS_SLOW    = 3'd4,
    POS_FAST    = 3'd5,
    POS_RESET   = 3'd6
  } pos_t;

  typedef struct packed {
    frame_status_t     status;
    logic [BYTE_W-1:0] fault;
    logic [RAW_W-1:0]  mem_raw;
    logic [RAW_W-1:0]  cur_raw;
    logic [BYTE_W-1:0] status_byte;
  } frame_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic pos_t decode_pos(input logic [BYTE_W-1:0] s);
    pos_t p;
    unique case (s)
      ST_BYTE_BOTTOM:  p = POS_BOTTOM;
      ST_BYTE_BETWEEN: p = POS_BETWEEN;
      ST_BYTE_MAX:     p = POS_MAX;
      ST_BYTE_SLOW:    p = POS_SLOW;
      ST_BYTE_FAST:    p = POS_FAST;
      ST_BYTE_RESET:   p = POS_RESET;
      default:         p = POS_UNKNOWN;
    endcase
    return p;
  endfunction

endpackage

[rtl/dsfp_front.sv]
// Front end: byte counting, header check, CRC and field capture per frame.
module dsfp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [dsfp_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       in_frame_start,
  output logic                       push,
  output dsfp_pkg::frame_t           frame
);
  import dsfp_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, eff_cnt;
  logic [CRC_W-1:0]  crc_r, crc_nxt, crc_base;
  logic              hdr_r, hdr_nxt, hdr_base;
  logic [BYTE_W-1:0] fault_r, fault_nxt;
  logic [RAW_W-1:0]  mem_r, mem_nxt;
  logic [RAW_W-1:0]  cur_r, cur_nxt;
  logic [BYTE_W-1:0] stat_r, stat_nxt;
  logic [BYTE_W-1:0] crc_lo_r, crc_lo_nxt;
  logic              active;

  always_comb begin
    eff_cnt  = in_frame_start ? '0 : cnt_r;
    crc_base = in_frame_start ? CRC_INIT : crc_r;
    hdr_base = in_frame_start ? 1'b0 : hdr_r;
    active   = in_valid && in_ready && (eff_cnt < FRAME_BYTES);

    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    fault_nxt  = fault_r;
    mem_nxt    = mem_r;
    cur_nxt    = cur_r;
    stat_nxt   = stat_r;
    crc_lo_nxt = crc_lo_r;
    push       = 1'b0;

    frame.fault       = fault_r;
    frame.mem_raw     = mem_r;
    frame.cur_raw     = cur_r;
    frame.status_byte = stat_r;
    if (!hdr_base) begin
      frame.status = FS_BAD_HEADER;
    end else if ({in_rx_byte, crc_lo_r} != crc_base) begin
      frame.status = FS_CRC_ERROR;
    end else begin
      frame.status = FS_OK;
    end

    if (active) begin
      cnt_nxt = eff_cnt + 4'd1;
      hdr_nxt = hdr_base;
      if (eff_cnt >= IDX_CRC_FIRST && eff_cnt < IDX_CRC_FIRST + CRC_BYTES) begin
        crc_nxt = crc_byte(crc_base, in_rx_byte);
      end else begin
        crc_nxt = crc_base;
      end
      unique case (eff_cnt)
        IDX_HDR0:   hdr_nxt = (in_rx_byte == HDR0);
        IDX_HDR1:   hdr_nxt = hdr_base && (in_rx_byte == HDR1);
        IDX_FAULT:  fault_nxt = in_rx_byte;
        IDX_MEM_HI: mem_nxt = {in_rx_byte, mem_r[BYTE_W-1:0]};
        IDX_MEM_LO: mem_nxt = {mem_r[RAW_W-1:BYTE_W], in_rx_byte};
        IDX_CUR_HI: cur_nxt = {in_rx_byte, cur_r[BYTE_W-1:0]};
        IDX_CUR_LO: cur_nxt = {cur_r[RAW_W-1:BYTE_W], in_rx_byte};
        IDX_STATUS: stat_nxt = in_rx_byte;
        IDX_CRC_LO: crc_lo_nxt = in_rx_byte;
        IDX_CRC_HI: push = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= FRAME_BYTES;
      crc_r    <= CRC_INIT;
      hdr_r    <= 1'b0;
      fault_r  <= '0;
      mem_r    <= '0;
      cur_r    <= '0;
      stat_r   <= '0;
      crc_lo_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      hdr_r    <= hdr_nxt;
      fault_r  <= fault_nxt;
      mem_r    <= mem_nxt;
      cur_r    <= cur_nxt;
      stat_r   <= stat_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

[rtl/dsfp_queue.sv]
// Small FIFO of classified frames between front end and back end.
module dsfp_queue #(
  parameter int DEPTH = dsfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dsfp_pkg::frame_t wr_frame,
  input  logic             pop,
  output dsfp_pkg::frame_t rd_frame,
  output logic             full,
  output logic             not_empty
);
  import dsfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] DEPTH_C  = CNT_QW'(DEPTH);

  frame_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full      = (cnt_r == DEPTH_C);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_frame  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_QW'(do_push) - CNT_QW'(do_pop);
    end
  end

endmodule

[rtl/dsfp_scale.sv]
// Three-stage raw-word to millimetre scaler using a reciprocal multiply.
module dsfp_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dsfp_pkg::RAW_W-1:0]    raw,
  output logic [dsfp_pkg::HEIGHT_W-1:0] mm
);
  import dsfp_pkg::*;

  localparam int X_W    = RAW_W + 1;
  localparam int PROD_W = RAW_W + RECIP_W;

  logic signed [X_W-1:0]     x;
  logic [RAW_W-1:0]          a_r, a2_r;
  logic                      neg_r, neg2_r;
  logic [PROD_W-1:0]         prod;
  logic [HEIGHT_W-1:0]       est_r;
  logic [SPAN_PROD_W-1:0]    num, sub, rem;
  logic [HEIGHT_W-1:0]       q;
  logic [HEIGHT_W-1:0]       mm_r;

  assign x = $signed({1'b0, raw}) - X_W'(RAW_OFFSET);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= x[X_W-1];
      a_r   <= x[X_W-1] ? RAW_W'(-x) : x[RAW_W-1:0];
    end
  end

  assign prod = PROD_W'(a_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      est_r  <= prod[RECIP_SHIFT +: HEIGHT_W];
      a2_r   <= a_r;
      neg2_r <= neg_r;
    end
  end

  // estimate is low by at most one
  always_comb begin
    num = SPAN_PROD_W'(a2_r) * SPAN_PROD_W'(H_SPAN);
    sub = SPAN_PROD_W'(est_r) * SPAN_PROD_W'(RAW_SPAN);
    rem = num - sub;
    q   = (rem >= SPAN_PROD_W'(RAW_SPAN)) ? est_r + 1'b1 : est_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_r <= neg2_r ? HEIGHT_W'(H_MIN) - q : HEIGHT_W'(H_MIN) + q;
    end
  end

  assign mm = mm_r;

endmodule

[rtl/dsfp_back.sv]
// Back end: height scaling pipeline, change detection and output register.
module dsfp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  dsfp_pkg::frame_t              q_frame,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_frame_status,
  output logic [dsfp_pkg::HEIGHT_W-1:0] out_current_height,
  output logic [dsfp_pkg::HEIGHT_W-1:0] out_memory_height,
  output logic [2:0]                    out_position_code,
  output logic [dsfp_pkg::BYTE_W-1:0]   out_fault_code,
  output logic                          out_current_changed,
  output logic                          out_memory_changed,
  output logic                          out_position_changed,
  output logic                          out_fault_changed,
  output logic                          out_position_unrecognized
);
  import dsfp_pkg::*;

  typedef struct packed {
    frame_status_t     status;
    logic [BYTE_W-1:0] fault;
    pos_t              pos;
    logic              unk;
  } side_t;

  logic                adv;
  logic [2:0]          v_r;
  side_t               s1_r, s2_r, s3_r;
  logic [HEIGHT_W-1:0] cur_mm, mem_mm;

  logic [HEIGHT_W-1:0] last_cur_r, last_mem_r;
  pos_t                last_pos_r;
  logic [BYTE_W-1:0]   last_fault_r;

  logic                out_valid_r;
  frame_status_t       o_status_r;
  logic [HEIGHT_W-1:0] o_cur_r, o_mem_r;
  pos_t                o_pos_r;
  logic [BYTE_W-1:0]   o_fault_r;
  logic                o_cc_r, o_mc_r, o_pc_r, o_fc_r, o_unk_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_not_empty;

  dsfp_scale u_scale_cur (.clk(clk), .en(adv), .raw(q_frame.cur_raw), .mm(cur_mm));
  dsfp_scale u_scale_mem (.clk(clk), .en(adv), .raw(q_frame.mem_raw), .mm(mem_mm));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.status <= q_frame.status;
      s1_r.fault  <= q_frame.fault;
      s1_r.pos    <= decode_pos(q_frame.status_byte);
      s1_r.unk    <= (decode_pos(q_frame.status_byte) == POS_UNKNOWN);
      s2_r        <= s1_r;
      s3_r        <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_valid_r  <= 1'b0;
      last_cur_r   <= '0;
      last_mem_r   <= '0;
      last_pos_r   <= POS_UNKNOWN;
      last_fault_r <= '0;
    end else if (adv) begin
      v_r         <= {v_r[1:0], q_not_empty};
      out_valid_r <= v_r[2];
      if (v_r[2] && s3_r.status == FS_OK) begin
        last_cur_r   <= cur_mm;
        last_mem_r   <= mem_mm;
        last_pos_r   <= s3_r.pos;
        last_fault_r <= s3_r.fault;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[2]) begin
      o_status_r <= s3_r.status;
      if (s3_r.status == FS_OK) begin
        o_cur_r   <= cur_mm;
        o_mem_r   <= mem_mm;
        o_pos_r   <= s3_r.pos;
        o_fault_r <= s3_r.fault;
        o_cc_r    <= (cur_mm != last_cur_r);
        o_mc_r    <= (mem_mm != last_mem_r);
        o_pc_r    <= (s3_r.pos != last_pos_r);
        o_fc_r    <= (s3_r.fault != last_fault_r);
        o_unk_r   <= s3_r.unk;
      end else begin
        o_cur_r   <= last_cur_r;
        o_mem_r   <= last_mem_r;
        o_pos_r   <= last_pos_r;
        o_fault_r <= last_fault_r;
        o_cc_r    <= 1'b0;
        o_mc_r    <= 1'b0;
        o_pc_r    <= 1'b0;
        o_fc_r    <= 1'b0;
        o_unk_r   <= 1'b0;
      end
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_frame_status          = o_status_r;
  assign out_current_height        = o_cur_r;
  assign out_memory_height         = o_mem_r;
  assign out_position_code         = o_pos_r;
  assign out_fault_code            = o_fault_r;
  assign out_current_changed       = o_cc_r;
  assign out_memory_changed        = o_mc_r;
  assign out_position_changed      = o_pc_r;
  assign out_fault_changed         = o_fc_r;
  assign out_position_unrecognized = o_unk_r;

endmodule

[rtl/desk_status_frame_parser.sv]
// Top level: desk status frame parser, one result per frame out.
// Throughput: one byte per cycle while in_ready is high; one result per 14-byte frame.
// Path: after the 14th byte's transaction the result is registered in the frame queue,
// the three-stage reciprocal-multiply height scaler and the output register.
// Reset: byte counter idle until a frame start, CRC at FFFF, last accepted values zero.
// The frame queue lets the back end stall on out_ready while bytes keep arriving.
module desk_status_frame_parser #(
  parameter int QUEUE_DEPTH = dsfp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dsfp_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_frame_status,
  output logic [dsfp_pkg::HEIGHT_W-1:0] out_current_height,
  output logic [dsfp_pkg::HEIGHT_W-1:0] out_memory_height,
  output logic [2:0]                    out_position_code,
  output logic [dsfp_pkg::BYTE_W-1:0]   out_fault_code,
  output logic                          out_current_changed,
  output logic                          out_memory_changed,
  output logic                          out_position_changed,
  output logic                          out_fault_changed,
  output logic                          out_position_unrecognized
);
  import dsfp_pkg::*;

  logic   push, pop, full, not_empty;
  frame_t wr_frame, rd_frame;

  assign in_ready = !full;

  dsfp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_frame_start(in_frame_start),
    .push          (push),
    .frame         (wr_frame)
  );

  dsfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_frame (wr_frame),
    .pop      (pop),
    .rd_frame (rd_frame),
    .full     (full),
    .not_empty(not_empty)
  );

  dsfp_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_not_empty              (not_empty),
    .q_frame                  (rd_frame),
    .q_pop                    (pop),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_frame_status         (out_frame_status),
    .out_current_height       (out_current_height),
    .out_memory_height        (out_memory_height),
    .out_position_code        (out_position_code),
    .out_fault_code           (out_fault_code),
    .out_current_changed      (out_current_changed),
    .out_memory_changed       (out_memory_changed),
    .out_position_changed     (out_position_changed),
    .out_fault_changed        (out_fault_changed),
    .out_position_unrecognized(out_position_unrecognized)
  );

endmodule
